FILE: src/prwt_pkg.sv
// Package for the PCI range window translation block.
// Holds the item structs, window entry type, state codes and constants.
// Used by pci_range_window_translate; depends on nothing else.
package prwt_pkg;

    localparam int MAX_WINDOWS_DEF = 8;

    localparam logic [31:0] CONF_HDR_BYTES = 32'd256;
    localparam int          IO_BUS_BIT     = 28;

    localparam logic [1:0] SPACE_CONFIG = 2'd0;
    localparam logic [1:0] SPACE_IO     = 2'd1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CFG_RANGE = 2'd1;
    localparam logic [1:0] ST_NO_WINDOW = 2'd2;

    localparam logic REQ_LOAD      = 1'b0;
    localparam logic REQ_TRANSLATE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  entry_index;
        logic [31:0] space_word;
        logic [31:0] addr_low;
        logic [31:0] size_word;
        logic [31:0] parent_hi_in;
        logic [31:0] parent_lo_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] bus_type;
        logic [31:0] out_addr;
        logic [31:0] out_size;
    } rsp_t;

    typedef struct packed {
        logic [31:0] child_hi;
        logic [31:0] child_lo;
        logic [31:0] size;
        logic [31:0] parent_hi;
        logic [31:0] parent_lo;
    } win_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_END,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

FILE: src/pci_range_window_translate.sv
// PCI outbound address window table with a sequential translation search.
// Depends on prwt_pkg for the item structs, state codes and constants.
//
// Usage: the request channel (req_valid, req_ready, req_data) carries two kinds
// of item. A load item writes one window entry into the table memory in the
// cycle it is accepted and gives no result. A translate item gives exactly one
// result on the response channel (rsp_valid, rsp_ready, rsp_data).
// The config channel (cfg_valid, cfg_ready, cfg_data) sets num_ranges; it is
// always ready and should be written only while the block is idle.
// A load item leaves the block idle and ready for another item. A translate
// item goes through the setup and end states, then scans until the first hit
// or until all C = min(num_ranges, MAX_WINDOWS) entries are searched (a config
// offset error skips the scan), and waits in the done state until its result is
// written to the output register. The scan issues one table read per cycle and
// compares each entry once it has passed the read data and stage-2 registers.
// A new item is accepted once the result is in the output register, even while
// it still waits there; a stalled receiver only holds the block when a second
// result is ready to be written.
// Reset clears num_ranges and all control state; the table is undefined
// until loaded and must be loaded before it is searched.
module pci_range_window_translate #(
    parameter int MAX_WINDOWS = prwt_pkg::MAX_WINDOWS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  prwt_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output prwt_pkg::rsp_t rsp_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [3:0]     cfg_data
);

    localparam int ADDR_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);

    prwt_pkg::state_t state_reg;
    prwt_pkg::state_t state_next;

    prwt_pkg::win_t mem [MAX_WINDOWS];
    prwt_pkg::win_t rd_data_reg;

    logic [3:0]       num_ranges_reg;
    logic [31:0]      req_hi_reg;
    logic [31:0]      req_lo_reg;
    logic [31:0]      req_sz_reg;
    logic [1:0]       space_reg;
    logic             cfg_err_reg;
    logic [31:0]      reg_begin_reg;
    logic [31:0]      reg_end_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] issue_reg;
    logic             s1_valid_reg;
    logic             s2_valid_reg;
    logic             s2_match_reg;
    logic [31:0]      s2_begin_reg;
    logic [31:0]      s2_end_reg;
    logic [31:0]      s2_parent_hi_reg;
    logic [31:0]      s2_parent_lo_reg;
    logic             found_reg;
    logic [31:0]      hit_bus_reg;
    logic [31:0]      hit_addr_reg;
    logic             rsp_valid_reg;
    prwt_pkg::rsp_t   rsp_data_reg;

    logic             in_accept;
    logic             load_we;
    logic             setup_en;
    logic             end_en;
    logic             scan_en;
    logic             rsp_load;
    logic             out_free;
    logic             hit3;
    logic             scan_done;
    logic             is_config;
    logic [1:0]       setup_space;
    logic             setup_cfg;
    logic [31:0]      setup_sz;
    logic [31:0]      setup_begin;
    logic             setup_err;
    logic [CNT_W-1:0] setup_count;
    logic [31:0]      s2_addend;
    logic [31:0]      s2_begin_next;
    logic [31:0]      s2_end_next;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    prwt_pkg::rsp_t   rsp_next;

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign in_accept = req_valid && req_ready;
    assign load_we   = in_accept && (req_data.req_type == prwt_pkg::REQ_LOAD)
                       && (int'(req_data.entry_index) < MAX_WINDOWS);
    assign wr_addr   = ADDR_W'(req_data.entry_index);
    assign rd_addr   = issue_reg[ADDR_W-1:0];
    assign is_config = (space_reg == prwt_pkg::SPACE_CONFIG);

    assign hit3 = s2_valid_reg && s2_match_reg
                  && (reg_begin_reg >= s2_begin_reg) && (reg_end_reg <= s2_end_reg);
    assign scan_done = (issue_reg >= count_reg) && !s1_valid_reg && !s2_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prwt_pkg::S_IDLE:
            begin
                if (in_accept && (req_data.req_type == prwt_pkg::REQ_TRANSLATE))
                begin
                    state_next = prwt_pkg::S_SETUP;
                end
            end
            prwt_pkg::S_SETUP:
            begin
                state_next = setup_err ? prwt_pkg::S_DONE : prwt_pkg::S_END;
            end
            prwt_pkg::S_END:
            begin
                state_next = prwt_pkg::S_SCAN;
            end
            prwt_pkg::S_SCAN:
            begin
                if (hit3 || scan_done)
                begin
                    state_next = prwt_pkg::S_DONE;
                end
            end
            prwt_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = prwt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = prwt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        setup_en  = 1'b0;
        end_en    = 1'b0;
        scan_en   = 1'b0;
        rsp_load  = 1'b0;
        unique case (state_reg)
            prwt_pkg::S_IDLE:  req_ready = 1'b1;
            prwt_pkg::S_SETUP: setup_en  = 1'b1;
            prwt_pkg::S_END:   end_en    = 1'b1;
            prwt_pkg::S_SCAN:  scan_en   = 1'b1;
            prwt_pkg::S_DONE:  rsp_load  = out_free;
            default:           req_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        setup_space = req_hi_reg[25:24];
        setup_cfg   = (setup_space == prwt_pkg::SPACE_CONFIG);
        setup_err   = setup_cfg && (req_lo_reg > prwt_pkg::CONF_HDR_BYTES);
        setup_begin = setup_cfg ? (req_lo_reg + req_hi_reg) : req_lo_reg;
        if (setup_cfg && ((req_sz_reg == 32'd0) || (req_sz_reg > prwt_pkg::CONF_HDR_BYTES)))
        begin
            setup_sz = prwt_pkg::CONF_HDR_BYTES;
        end
        else
        begin
            setup_sz = req_sz_reg;
        end
        if (int'(num_ranges_reg) > MAX_WINDOWS)
        begin
            setup_count = CNT_W'(MAX_WINDOWS);
        end
        else
        begin
            setup_count = CNT_W'(num_ranges_reg);
        end
    end

    always_comb
    begin
        s2_addend     = is_config ? rd_data_reg.child_hi : 32'd0;
        s2_begin_next = rd_data_reg.child_lo + s2_addend;
        s2_end_next   = rd_data_reg.child_lo + s2_addend + rd_data_reg.size - 32'd1;
    end

    always_comb
    begin
        rsp_next = '0;
        if (cfg_err_reg)
        begin
            rsp_next.status = prwt_pkg::ST_CFG_RANGE;
        end
        else if (!found_reg)
        begin
            rsp_next.status = prwt_pkg::ST_NO_WINDOW;
        end
        else
        begin
            rsp_next.status   = prwt_pkg::ST_OK;
            rsp_next.bus_type = hit_bus_reg;
            rsp_next.out_addr = hit_addr_reg;
            rsp_next.out_size = req_sz_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[wr_addr] <= '{child_hi:  req_data.space_word,
                              child_lo:  req_data.addr_low,
                              size:      req_data.size_word,
                              parent_hi: req_data.parent_hi_in,
                              parent_lo: req_data.parent_lo_in};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_hi_reg <= req_data.space_word;
            req_lo_reg <= req_data.addr_low;
            req_sz_reg <= req_data.size_word;
        end
        if (setup_en)
        begin
            space_reg     <= setup_space;
            reg_begin_reg <= setup_begin;
            req_sz_reg    <= setup_sz;
            count_reg     <= setup_count;
        end
        if (end_en)
        begin
            reg_end_reg <= reg_begin_reg + req_sz_reg - 32'd1;
        end
        s2_match_reg     <= (rd_data_reg.child_hi[25:24] == space_reg);
        s2_begin_reg     <= s2_begin_next;
        s2_end_reg       <= s2_end_next;
        s2_parent_hi_reg <= rd_data_reg.parent_hi;
        s2_parent_lo_reg <= rd_data_reg.parent_lo;
        if (scan_en && hit3)
        begin
            hit_bus_reg  <= s2_parent_hi_reg
                            | ((space_reg == prwt_pkg::SPACE_IO)
                               ? (32'd1 << prwt_pkg::IO_BUS_BIT) : 32'd0);
            hit_addr_reg <= reg_begin_reg - s2_begin_reg + s2_parent_lo_reg;
        end
        if (rsp_load)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= prwt_pkg::S_IDLE;
            num_ranges_reg <= 4'd0;
            cfg_err_reg    <= 1'b0;
            issue_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                num_ranges_reg <= cfg_data;
            end
            if (setup_en)
            begin
                cfg_err_reg <= setup_err;
                found_reg   <= 1'b0;
                issue_reg   <= '0;
            end
            if (scan_en)
            begin
                s1_valid_reg <= (issue_reg < count_reg);
                s2_valid_reg <= s1_valid_reg;
                if (issue_reg < count_reg)
                begin
                    issue_reg <= issue_reg + CNT_W'(1);
                end
                if (hit3)
                begin
                    found_reg <= 1'b1;
                end
            end
            else
            begin
                s1_valid_reg <= 1'b0;
                s2_valid_reg <= 1'b0;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_ready_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("Request taken while the table scan is still active.");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prwt_pkg::S_SCAN) |-> (issue_reg <= count_reg))
        else $error("Scan read index ran past the entry count.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prwt_pkg::S_SCAN) |-> (int'(count_reg) <= MAX_WINDOWS))
        else $error("Entry count exceeds the table depth.");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_data.status != prwt_pkg::ST_OK))
        |-> ((rsp_data.bus_type == 32'd0) && (rsp_data.out_addr == 32'd0)
             && (rsp_data.out_size == 32'd0)))
        else $error("Error item carries nonzero result fields.");

    a_rsp_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == prwt_pkg::S_DONE))
        else $error("Result item raised outside the completion state.");
`endif

endmodule

FILE: test/tb_pci_range_window_translate.sv
`timescale 1ns / 1ps
// Testbench for pci_range_window_translate: loads window tables, sends translate items
// and checks each result against a predictor that tracks the table and num_ranges.
// Depends on prwt_pkg and the block's RTL only.
module tb_pci_range_window_translate;

    localparam int WINDOWS       = prwt_pkg::MAX_WINDOWS_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int BLOCK_ITEMS   = 50;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    prwt_pkg::req_t req_data = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    prwt_pkg::rsp_t rsp_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [3:0]     cfg_data = '0;

    prwt_pkg::win_t table_shadow [WINDOWS];
    logic [3:0]     range_count = '0;
    prwt_pkg::rsp_t pending [$];
    prwt_pkg::rsp_t want_rsp;
    int             send_gap_pct = 0;
    int             rcv_stall_pct = 0;
    int             error_count = 0;
    int             cycle_count = 0;

    pci_range_window_translate DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("ERROR at %0t: %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic prwt_pkg::rsp_t translate_spec(input prwt_pkg::req_t r);
        prwt_pkg::rsp_t res;
        logic [1:0]     sp;
        logic [31:0]    rb;
        logic [31:0]    re;
        logic [31:0]    sz;
        logic [31:0]    wb;
        logic [31:0]    we;
        logic [31:0]    hit_base;
        int             limit;
        int             hit_idx;
        res = '0;
        sp = r.space_word[25:24];
        rb = r.addr_low;
        sz = r.size_word;
        hit_idx = -1;
        hit_base = '0;
        if (sp == prwt_pkg::SPACE_CONFIG)
        begin
            if (rb > prwt_pkg::CONF_HDR_BYTES)
            begin
                res.status = prwt_pkg::ST_CFG_RANGE;
                return res;
            end
            if (sz == 32'd0 || sz > prwt_pkg::CONF_HDR_BYTES)
                sz = prwt_pkg::CONF_HDR_BYTES;
            rb = rb + r.space_word;
        end
        re = rb + sz - 32'd1;
        limit = (int'(range_count) > WINDOWS) ? WINDOWS : int'(range_count);
        for (int n = 0; n < limit; n++)
        begin
            if (hit_idx < 0 && table_shadow[n].child_hi[25:24] == sp)
            begin
                wb = table_shadow[n].child_lo;
                if (sp == prwt_pkg::SPACE_CONFIG)
                    wb = wb + table_shadow[n].child_hi;
                we = wb + table_shadow[n].size - 32'd1;
                if (rb >= wb && re <= we)
                begin
                    hit_idx = n;
                    hit_base = wb;
                end
            end
        end
        if (hit_idx < 0)
        begin
            res.status = prwt_pkg::ST_NO_WINDOW;
            return res;
        end
        res.status = prwt_pkg::ST_OK;
        res.bus_type = table_shadow[hit_idx].parent_hi;
        if (sp == prwt_pkg::SPACE_IO)
            res.bus_type[prwt_pkg::IO_BUS_BIT] = 1'b1;
        res.out_addr = rb - hit_base + table_shadow[hit_idx].parent_lo;
        res.out_size = sz;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending.size() == 0)
                    report_error("result with no translate outstanding, status",
                                 32'(rsp_data.status), 32'd0);
                else
                begin
                    want_rsp = pending.pop_front();
                    if (rsp_data.status !== want_rsp.status)
                        report_error("status", 32'(rsp_data.status),
                                     32'(want_rsp.status));
                    if (rsp_data.bus_type !== want_rsp.bus_type)
                        report_error("bus_type", rsp_data.bus_type, want_rsp.bus_type);
                    if (rsp_data.out_addr !== want_rsp.out_addr)
                        report_error("out_addr", rsp_data.out_addr, want_rsp.out_addr);
                    if (rsp_data.out_size !== want_rsp.out_size)
                        report_error("out_size", rsp_data.out_size, want_rsp.out_size);
                end
            end
            rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic send_item(input prwt_pkg::req_t item);
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (item.req_type == prwt_pkg::REQ_TRANSLATE)
            pending.push_back(translate_spec(item));
        else if (item.entry_index < WINDOWS)
            table_shadow[item.entry_index] = '{child_hi:  item.space_word,
                                               child_lo:  item.addr_low,
                                               size:      item.size_word,
                                               parent_hi: item.parent_hi_in,
                                               parent_lo: item.parent_lo_in};
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        req_valid <= 1'b0;
        while (pending.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending.size() != 0)
        begin
            report_error("translate results never returned, count",
                         32'(pending.size()), 32'd0);
            pending.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_range_count(input logic [3:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        range_count = value;
    endtask

    function automatic prwt_pkg::req_t random_item();
        prwt_pkg::req_t r;
        r.req_type = 1'($urandom_range(1));
        r.entry_index = 3'($urandom_range(7));
        r.space_word = $urandom;
        r.addr_low = $urandom;
        r.size_word = $urandom;
        r.parent_hi_in = $urandom;
        r.parent_lo_in = $urandom;
        return r;
    endfunction

    function automatic logic [31:0] pick_offset(input logic [31:0] span);
        case ($urandom_range(3))
            0: return 32'd0;
            1: return span;
            default: return $urandom_range(span, 0);
        endcase
    endfunction

    function automatic prwt_pkg::req_t random_window();
        prwt_pkg::req_t r;
        logic [1:0]     sp;
        r = random_item();
        r.req_type = prwt_pkg::REQ_LOAD;
        sp = 2'($urandom_range(3));
        r.space_word[25:24] = sp;
        if (sp == prwt_pkg::SPACE_CONFIG)
        begin
            r.addr_low = $urandom_range(32'hFFFF, 0);
            r.size_word = $urandom_range(32'h1_0000, 1);
        end
        else
        begin
            case ($urandom_range(9))
                0: r.size_word = 32'd0;
                1: r.size_word = 32'hFFFF_FFFF;
                2, 3: r.size_word = $urandom;
                default: r.size_word = $urandom_range(32'h1_0000, 1);
            endcase
        end
        return r;
    endfunction

    // Builds a request that lands inside window n, so most of the scan logic is reached.
    function automatic prwt_pkg::req_t targeted_spec(input int n);
        prwt_pkg::req_t r;
        prwt_pkg::win_t w;
        logic [1:0]     sp;
        logic [31:0]    eff;
        logic [31:0]    off;
        logic [31:0]    span;
        w = table_shadow[n];
        sp = w.child_hi[25:24];
        r = random_item();
        r.req_type = prwt_pkg::REQ_TRANSLATE;
        if (sp == prwt_pkg::SPACE_CONFIG)
        begin
            case ($urandom_range(3))
                0: r.size_word = 32'd0;
                1: r.size_word = $urandom;
                default: r.size_word = $urandom_range(256, 1);
            endcase
            eff = (r.size_word == 32'd0 || r.size_word > prwt_pkg::CONF_HDR_BYTES) ?
                  prwt_pkg::CONF_HDR_BYTES : r.size_word;
            off = (w.size > eff) ? pick_offset(w.size - eff) : 32'd0;
            r.addr_low = pick_offset(prwt_pkg::CONF_HDR_BYTES);
            r.space_word = w.child_lo + w.child_hi + off - r.addr_low;
            r.space_word[25:24] = prwt_pkg::SPACE_CONFIG;
        end
        else
        begin
            span = (w.size == 32'd0 || w.size > 32'd64) ? 32'd64 : w.size;
            r.size_word = ($urandom_range(19) == 0) ? 32'd0 : $urandom_range(span, 1);
            if (w.size == 32'd0)
                off = $urandom;
            else if (w.size >= r.size_word)
                off = pick_offset(w.size - r.size_word);
            else
                off = 32'd0;
            r.addr_low = w.child_lo + off;
            r.space_word[25:24] = sp;
        end
        return r;
    endfunction

    task automatic load_window(input logic [2:0] idx, input logic [31:0] hi,
                               input logic [31:0] lo, input logic [31:0] size,
                               input logic [31:0] phi, input logic [31:0] plo);
        prwt_pkg::req_t r;
        r = '{req_type: prwt_pkg::REQ_LOAD, entry_index: idx, space_word: hi,
              addr_low: lo, size_word: size, parent_hi_in: phi, parent_lo_in: plo};
        send_item(r);
    endtask

    task automatic send_translate(input logic [31:0] hi, input logic [31:0] lo,
                                  input logic [31:0] size);
        prwt_pkg::req_t r;
        r = random_item();
        r.req_type = prwt_pkg::REQ_TRANSLATE;
        r.space_word = hi;
        r.addr_low = lo;
        r.size_word = size;
        send_item(r);
    endtask

    // At its reset value num_ranges scans nothing: no window, or a config offset error.
    task automatic test_reset_state();
        send_translate(32'h0200_0000, 32'h0000_0000, 32'h0000_0010);
        send_translate(32'h0000_0000, 32'h0000_0101, 32'h0000_0000);
    endtask

    // Every entry is loaded here before any scan can reach it.
    task automatic test_window_table();
        load_window(3'd0, 32'h0000_0800, 32'h0000_0000, 32'h0000_1000,
                    32'h0000_0000, 32'hF000_0000);
        load_window(3'd1, 32'h0100_0000, 32'h0000_1000, 32'h0000_1000,
                    32'h0000_0001, 32'h0000_0000);
        load_window(3'd2, 32'h0200_0000, 32'h8000_0000, 32'h1000_0000,
                    32'hFFFF_FFFF, 32'hC000_0000);
        load_window(3'd3, 32'hFF00_0000, 32'hFFFF_F000, 32'h0000_1000,
                    32'h1234_5678, 32'hFFFF_FFFF);
        load_window(3'd4, 32'h0200_0000, 32'h0000_0000, 32'h0000_0000,
                    32'h0000_0002, 32'h0000_1000);
        load_window(3'd5, 32'h0100_0000, 32'h0000_1800, 32'h0000_0100,
                    32'h0000_0003, 32'h0000_4000);
        load_window(3'd6, 32'hFCFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h0000_0004, 32'hAAAA_5555);
        load_window(3'd7, 32'h0100_0000, 32'h0000_0000, 32'h0000_0010,
                    32'h0000_0005, 32'h0000_0000);
        write_range_count(4'd8);
        send_translate(32'h0000_0800, 32'h0000_0000, 32'h0000_0000);
        send_translate(32'h0000_0800, 32'h0000_0100, 32'hFFFF_FFFF);
        send_translate(32'h0000_0800, 32'h0000_0101, 32'h0000_0004);
        send_translate(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
        send_translate(32'h0100_0000, 32'h0000_1800, 32'h0000_0010);
        send_translate(32'h0100_0000, 32'h0000_1F00, 32'h0000_0200);
        send_translate(32'h0200_0000, 32'h8000_0010, 32'h0000_0004);
        send_translate(32'h0200_0000, 32'h7FFF_FFFF, 32'h0000_0002);
        send_translate(32'h0300_0000, 32'hFFFF_FFF0, 32'h0000_0010);
        send_translate(32'h0300_0000, 32'hFFFF_F000, 32'h0000_0000);
        send_translate(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    endtask

    // A count above the table size searches the whole table; a smaller one cuts the scan.
    task automatic test_count_limits();
        write_range_count(4'd15);
        send_translate(32'h0100_0000, 32'h0000_0005, 32'h0000_0001);
        write_range_count(4'd7);
        send_translate(32'h0100_0000, 32'h0000_0005, 32'h0000_0001);
    endtask

    task automatic test_random_traffic(input int items, input int gap_pct,
                                       input int stall_pct);
        int             limit;
        int             sel;
        prwt_pkg::req_t r;
        send_gap_pct = gap_pct;
        rcv_stall_pct = stall_pct;
        for (int i = 0; i < items; i++)
        begin
            if (i % BLOCK_ITEMS == 0)
                write_range_count(($urandom_range(4) == 0) ? 4'($urandom_range(15)) :
                                  4'($urandom_range(8, 3)));
            limit = (int'(range_count) > WINDOWS) ? WINDOWS : int'(range_count);
            sel = $urandom_range(99);
            if (sel < 10)
                r = random_window();
            else if (sel < 25 || limit == 0)
            begin
                r = random_item();
                r.req_type = prwt_pkg::REQ_TRANSLATE;
            end
            else
                r = targeted_spec($urandom_range(limit - 1, 0));
            send_item(r);
        end
    endtask

    initial
    begin
        send_gap_pct = 12;
        rcv_stall_pct = 87;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_window_table();
        test_count_limits();
        test_random_traffic(420, 12, 87);
        test_random_traffic(420, 87, 12);
        test_random_traffic(410, 0, 0);
        wait_idle();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/prwt_pkg.sv
src/pci_range_window_translate.sv
test/tb_pci_range_window_translate.sv
